@@ hdl/beacon_presence_tracker_assert.svh @@
// Assertion macros used by the checker file of the beacon presence tracker.
`ifndef BEACON_PRESENCE_TRACKER_ASSERT_SVH
`define BEACON_PRESENCE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define BPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpt assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define BPT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpt assertion failed");

`endif

@@ hdl/bpt_pkg.sv @@
// Types, codes and helper functions of the beacon presence tracker.
`default_nettype none
package bpt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;

  localparam logic [1:0] OP_SIGHT = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_WEAK      = 3'd2;
  localparam logic [2:0] ST_IGNORED   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_SCAN_DONE = 3'd5;
  localparam logic [2:0] ST_DEPARTED  = 3'd6;

  localparam logic [1:0] REG_FLOOR  = 2'd0;
  localparam logic [1:0] REG_INSIDE = 2'd1;
  localparam logic [1:0] REG_WEAK   = 2'd2;
  localparam logic [1:0] REG_LEAVE  = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [47:0]        beacon_address;
    logic signed [7:0]  signal_strength;
    logic [15:0]        battery_level;
    logic [31:0]        time_now;
  } item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         slot;
    logic               present;
    logic [47:0]        out_address;
    logic signed [7:0]  peak_strength;
    logic [15:0]        inside_count;
    logic [15:0]        out_battery;
    logic [31:0]        depart_time;
    logic [6:0]         departures;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [47:0]        address;
    logic signed [7:0]  peak;
    logic [15:0]        inside_cnt;
    logic [15:0]        miss;
    logic [15:0]        weak_cnt;
    logic               present;
    logic               scheduled;
    logic [15:0]        battery;
    logic [31:0]        stamp;
  } entry_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/bpt_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/beacon_presence_tracker.sv @@
// Beacon presence tracker: per-slot table in one RAM, walked one slot per cycle.
// A sighting searches the table, then updates the slot it hit; end of scan and drain
// walk the whole table, one RAM read per cycle.
// One item is processed at a time; busy is high until the last result is shown.
// Results are one-cycle strobes; the receiver cannot stall them.
// Synchronous reset clears the used and seen bits and restores register defaults.
`default_nettype none
module beacon_presence_tracker #(
  parameter int TABLE_DEPTH = bpt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire bpt_pkg::item_t  item,
  output logic                 result_valid,
  output bpt_pkg::result_t     result,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bpt_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_UPD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  item_t req;
  logic [IW-1:0] idx, pipe_idx, free_idx, hit_idx;
  logic iss, pipe_v, free_found;
  logic [6:0] deps;
  logic pend_v;
  result_t pend;
  entry_t ent;
  logic [TABLE_DEPTH-1:0] used, seen;
  logic signed [7:0] rssi_floor;
  logic [15:0] inside_threshold, weak_threshold, leave_threshold;

  logic ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t ram_wdata, rdata;

  bpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(idx), .rdata(rdata)
  );

  logic is_strong, hit, last_pipe, cur_used, cur_free_v;
  logic [IW-1:0] cur_free_idx;
  entry_t aged, upd, created;
  logic leave, dep_now;
  logic [16:0] leave_sum;
  logic [15:0] weak_n;
  logic drain_hit;
  result_t drain_res;

  assign cur_used = used[pipe_idx];
  assign is_strong = req.signal_strength > rssi_floor;
  assign hit = pipe_v && cur_used && (rdata.address == req.beacon_address);
  assign last_pipe = pipe_v && (pipe_idx == LAST_IDX);
  assign cur_free_v = free_found || (pipe_v && !cur_used);
  assign cur_free_idx = free_found ? free_idx : pipe_idx;
  assign drain_hit = pipe_v && cur_used && rdata.scheduled;

  always_comb begin
    aged = rdata;
    if (!seen[pipe_idx]) begin
      aged.miss = sat_add16(rdata.miss, 17'd1);
    end
    leave_sum = {1'b0, aged.miss} + {1'b0, aged.weak_cnt};
    leave = leave_sum >= {1'b0, leave_threshold};
    dep_now = leave && rdata.present;
    if (dep_now) begin
      aged.present = 1'b0;
      aged.scheduled = 1'b1;
      aged.stamp = req.time_now;
    end

    upd = ent;
    weak_n = sat_add16(ent.weak_cnt, 17'd1);
    if (is_strong) begin
      if (req.signal_strength > ent.peak) begin
        upd.peak = req.signal_strength;
      end
      upd.inside_cnt = sat_add16(ent.inside_cnt, {1'b0, ent.miss} + 17'd1);
      upd.miss = '0;
      upd.weak_cnt = '0;
      if (upd.inside_cnt >= inside_threshold) begin
        upd.present = 1'b1;
        upd.battery = req.battery_level;
      end
    end else begin
      upd.weak_cnt = weak_n;
      if (!ent.present && !ent.scheduled && weak_n >= weak_threshold) begin
        upd.inside_cnt = '0;
      end
    end

    created = '0;
    created.address = req.beacon_address;
    created.peak = req.signal_strength;
    created.inside_cnt = 16'd1;
    created.battery = 16'hFFFF;

    drain_res = '0;
    drain_res.status = ST_DEPARTED;
    drain_res.slot = 6'(pipe_idx);
    drain_res.out_address = rdata.address;
    drain_res.peak_strength = rdata.peak;
    drain_res.inside_count = rdata.inside_cnt;
    drain_res.out_battery = rdata.battery;
    drain_res.depart_time = rdata.stamp;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pipe_idx;
    ram_wdata = aged;
    unique case (state)
      S_SCAN: begin
        if (req.operation == OP_SCAN && pipe_v && cur_used) begin
          ram_we = 1'b1;
        end else if (req.operation == OP_SIGHT && last_pipe && !hit && is_strong &&
                     cur_free_v) begin
          ram_we = 1'b1;
          ram_waddr = cur_free_idx;
          ram_wdata = created;
        end
      end
      S_UPD: begin
        ram_we = 1'b1;
        ram_waddr = hit_idx;
        ram_wdata = upd;
      end
      S_IDLE, S_FLUSH: begin
        ram_we = 1'b0;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iss <= 1'b0;
      pipe_v <= 1'b0;
      free_found <= 1'b0;
      pend_v <= 1'b0;
      used <= '0;
      seen <= '0;
      result_valid <= 1'b0;
      rssi_floor <= -8'sd80;
      inside_threshold <= 16'd3;
      weak_threshold <= 16'd3;
      leave_threshold <= 16'd3;
    end else begin
      result_valid <= 1'b0;
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          REG_FLOOR:  rssi_floor <= pwdata[7:0];
          REG_INSIDE: inside_threshold <= pwdata[15:0];
          REG_WEAK:   weak_threshold <= pwdata[15:0];
          REG_LEAVE:  leave_threshold <= pwdata[15:0];
          default:    rssi_floor <= rssi_floor;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= item;
            idx <= '0;
            free_found <= 1'b0;
            deps <= '0;
            pend_v <= 1'b0;
            pipe_v <= 1'b0;
            if (item.operation == OP_SIGHT || item.operation == OP_SCAN ||
                item.operation == OP_DRAIN) begin
              iss <= 1'b1;
              state <= S_SCAN;
            end else begin
              result <= '0;
              result.status <= ST_IGNORED;
              result.last <= 1'b1;
              result_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (iss) begin
            pipe_v <= 1'b1;
            pipe_idx <= idx;
            if (idx == LAST_IDX) begin
              iss <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            pipe_v <= 1'b0;
          end
          priority case (req.operation)
            OP_SIGHT: begin
              if (pipe_v && !free_found && !cur_used) begin
                free_found <= 1'b1;
                free_idx <= pipe_idx;
              end
              if (hit) begin
                ent <= rdata;
                hit_idx <= pipe_idx;
                iss <= 1'b0;
                pipe_v <= 1'b0;
                state <= S_UPD;
              end else if (last_pipe) begin
                result <= '0;
                result.last <= 1'b1;
                result_valid <= 1'b1;
                state <= S_IDLE;
                if (!is_strong) begin
                  result.status <= ST_IGNORED;
                end else if (!cur_free_v) begin
                  result.status <= ST_FULL;
                end else begin
                  result.status <= ST_CREATED;
                  result.slot <= 6'(cur_free_idx);
                  result.peak_strength <= req.signal_strength;
                  result.inside_count <= 16'd1;
                  result.out_battery <= 16'hFFFF;
                  used[cur_free_idx] <= 1'b1;
                  seen[cur_free_idx] <= 1'b1;
                end
              end
            end
            OP_SCAN: begin
              if (pipe_v && cur_used) begin
                if (dep_now) begin
                  deps <= deps + 7'd1;
                end else if (leave && !rdata.scheduled) begin
                  used[pipe_idx] <= 1'b0;
                end
              end
              if (last_pipe) begin
                result <= '0;
                result.status <= ST_SCAN_DONE;
                result.departures <= deps + 7'(cur_used && dep_now);
                result.last <= 1'b1;
                result_valid <= 1'b1;
                seen <= '0;
                state <= S_IDLE;
              end
            end
            default: begin
              if (drain_hit) begin
                used[pipe_idx] <= 1'b0;
                pend <= drain_res;
                pend_v <= 1'b1;
                if (pend_v) begin
                  result <= pend;
                  result_valid <= 1'b1;
                end
              end
              if (last_pipe) begin
                state <= S_FLUSH;
              end
            end
          endcase
        end
        S_UPD: begin
          seen[hit_idx] <= 1'b1;
          result <= '0;
          result.status <= is_strong ? ST_UPDATED : ST_WEAK;
          result.slot <= 6'(hit_idx);
          result.present <= upd.present;
          result.peak_strength <= upd.peak;
          result.inside_count <= upd.inside_cnt;
          result.out_battery <= upd.battery;
          result.last <= 1'b1;
          result_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_FLUSH: begin
          if (pend_v) begin
            result <= pend;
            result.last <= 1'b1;
            result_valid <= 1'b1;
          end
          pend_v <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_FLOOR:  prdata[7:0] = rssi_floor;
      REG_INSIDE: prdata[15:0] = inside_threshold;
      REG_WEAK:   prdata[15:0] = weak_threshold;
      REG_LEAVE:  prdata[15:0] = leave_threshold;
      default:    prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/bpt_checker.sv @@
// Port-level checks of the beacon presence tracker and their binding.
`default_nettype none
`include "beacon_presence_tracker_assert.svh"
module bpt_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire bpt_pkg::item_t   item,
  input wire logic             result_valid,
  input wire bpt_pkg::result_t result
);
  import bpt_pkg::*;

  logic op_known;

  assign op_known = (item.operation == OP_SIGHT) || (item.operation == OP_SCAN) ||
                    (item.operation == OP_DRAIN);

  `BPT_ASSERT_NXT(a_start_busy, start && !busy && op_known, busy)
  `BPT_ASSERT_IMP(a_single_last, result_valid && result.status != ST_DEPARTED, result.last)
  `BPT_ASSERT_IMP(a_last_idle, result_valid && result.last, !busy)
  `BPT_ASSERT_IMP(a_rise_quiet, $rose(busy), !result_valid)
endmodule

bind beacon_presence_tracker bpt_checker u_bpt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
  .result_valid(result_valid), .result(result)
);
`default_nettype wire

@@ tb/beacon_presence_tracker_tb.sv @@
// Self-checking testbench of the beacon presence tracker: directed table, then random phases.
`timescale 1ns / 100ps
`default_nettype none
module beacon_presence_tracker_tb;
  import bpt_pkg::*;

  localparam logic [1:0] OP_BAD = 2'd3;
  localparam int DEPTH = 64;
  localparam int SETTLE = 80;

  typedef struct {
    logic [1:0]        op;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic [15:0]       batt;
    logic [31:0]       now;
    bit                typed;
    logic [2:0]        want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic result_valid;
  result_t result;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  beacon_presence_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic signed [7:0] floor_q;
  logic [15:0] inside_thr;
  logic [15:0] weak_thr;
  logic [15:0] leave_thr;
  bit in_use[DEPTH];
  bit was_seen[DEPTH];
  entry_t beacon_tab[DEPTH];
  result_t expected_results[$];
  logic [47:0] addr_pool[72];
  int errors = 0;

  stim_row_t opening_rows[18] = '{
    '{OP_SIGHT, 48'h0, 8'sd127, 16'h0000, 32'h0, 1'b1, ST_CREATED},
    '{OP_SIGHT, 48'hFFFF_FFFF_FFFF, -8'sd79, 16'hFFFF, 32'h0, 1'b1, ST_CREATED},
    '{OP_SIGHT, 48'h5, -8'sd128, 16'h0, 32'h0, 1'b1, ST_IGNORED},
    '{OP_SIGHT, 48'h0, -8'sd80, 16'h0, 32'h0, 1'b1, ST_WEAK},
    '{OP_SIGHT, 48'h0, 8'sd100, 16'hFFFF, 32'h0, 1'b0, ST_UPDATED},
    '{OP_SIGHT, 48'h0, 8'sd127, 16'h1234, 32'h0, 1'b0, ST_UPDATED},
    '{OP_BAD, 48'hFFFF_FFFF_FFFF, 8'sd1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_IGNORED},
    '{OP_DRAIN, 48'h0, 8'sd0, 16'h0, 32'h0, 1'b0, ST_IGNORED},
    '{OP_SIGHT, 48'hFFFF_FFFF_FFFF, -8'sd128, 16'h0, 32'h0, 1'b0, ST_WEAK},
    '{OP_SIGHT, 48'hFFFF_FFFF_FFFF, -8'sd128, 16'h0, 32'h0, 1'b0, ST_WEAK},
    '{OP_SCAN, 48'h0, 8'sd0, 16'h0, 32'h0, 1'b1, ST_SCAN_DONE},
    '{OP_SCAN, 48'h0, 8'sd0, 16'h0, 32'hFFFF_FFFF, 1'b0, ST_SCAN_DONE},
    '{OP_SCAN, 48'h0, 8'sd0, 16'h0, 32'h8000_0000, 1'b0, ST_SCAN_DONE},
    '{OP_SIGHT, 48'h0, -8'sd100, 16'h0, 32'h0, 1'b0, ST_WEAK},
    '{OP_SIGHT, 48'h0, 8'sd50, 16'h5555, 32'h0, 1'b0, ST_UPDATED},
    '{OP_DRAIN, 48'h0, 8'sd0, 16'h0, 32'h0, 1'b0, ST_DEPARTED},
    '{OP_SCAN, 48'h0, 8'sd0, 16'h0, 32'h1, 1'b0, ST_SCAN_DONE},
    '{OP_DRAIN, 48'h0, 8'sd0, 16'h0, 32'h0, 1'b0, ST_DEPARTED}
  };

  function automatic logic [15:0] sat16(input int unsigned s);
    return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic result_t entry_result(input logic [2:0] st, input int i);
    result_t r;
    r = '0;
    r.status = st;
    r.slot = i[5:0];
    r.present = beacon_tab[i].present;
    r.peak_strength = beacon_tab[i].peak;
    r.inside_count = beacon_tab[i].inside_cnt;
    r.out_battery = beacon_tab[i].battery;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t bare_result(input logic [2:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic track_item(input item_t it);
    int hit;
    int deps;
    result_t r;
    result_t drained[$];
    hit = -1;
    deps = 0;
    case (it.operation)
      OP_SIGHT: begin
        for (int i = 0; i < DEPTH; i++)
          if (hit < 0 && in_use[i] && beacon_tab[i].address == it.beacon_address) hit = i;
        if (it.signal_strength > floor_q) begin
          if (hit < 0) begin
            for (int i = 0; i < DEPTH; i++)
              if (hit < 0 && !in_use[i]) hit = i;
            if (hit < 0) begin
              expected_results.push_back(bare_result(ST_FULL));
            end else begin
              in_use[hit] = 1'b1;
              was_seen[hit] = 1'b1;
              beacon_tab[hit] = '0;
              beacon_tab[hit].address = it.beacon_address;
              beacon_tab[hit].peak = it.signal_strength;
              beacon_tab[hit].inside_cnt = 16'd1;
              beacon_tab[hit].battery = 16'hFFFF;
              expected_results.push_back(entry_result(ST_CREATED, hit));
            end
          end else begin
            if (it.signal_strength > beacon_tab[hit].peak)
              beacon_tab[hit].peak = it.signal_strength;
            beacon_tab[hit].inside_cnt = sat16(beacon_tab[hit].inside_cnt +
                                               beacon_tab[hit].miss + 1);
            beacon_tab[hit].miss = '0;
            beacon_tab[hit].weak_cnt = '0;
            if (beacon_tab[hit].inside_cnt >= inside_thr) begin
              beacon_tab[hit].present = 1'b1;
              beacon_tab[hit].battery = it.battery_level;
            end
            was_seen[hit] = 1'b1;
            expected_results.push_back(entry_result(ST_UPDATED, hit));
          end
        end else if (hit < 0) begin
          expected_results.push_back(bare_result(ST_IGNORED));
        end else begin
          beacon_tab[hit].weak_cnt = sat16(beacon_tab[hit].weak_cnt + 1);
          if (!beacon_tab[hit].present && !beacon_tab[hit].scheduled &&
              beacon_tab[hit].weak_cnt >= weak_thr)
            beacon_tab[hit].inside_cnt = '0;
          was_seen[hit] = 1'b1;
          expected_results.push_back(entry_result(ST_WEAK, hit));
        end
      end
      OP_SCAN: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (in_use[i]) begin
            if (!was_seen[i]) beacon_tab[i].miss = sat16(beacon_tab[i].miss + 1);
            if (int'(beacon_tab[i].miss) + int'(beacon_tab[i].weak_cnt) >= int'(leave_thr)) begin
              if (beacon_tab[i].present) begin
                beacon_tab[i].present = 1'b0;
                beacon_tab[i].scheduled = 1'b1;
                beacon_tab[i].stamp = it.time_now;
                deps++;
              end else if (!beacon_tab[i].scheduled) begin
                in_use[i] = 1'b0;
              end
            end
          end
          was_seen[i] = 1'b0;
        end
        r = bare_result(ST_SCAN_DONE);
        r.departures = deps[6:0];
        expected_results.push_back(r);
      end
      OP_DRAIN: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (in_use[i] && beacon_tab[i].scheduled) begin
            r = '0;
            r.status = ST_DEPARTED;
            r.slot = i[5:0];
            r.out_address = beacon_tab[i].address;
            r.peak_strength = beacon_tab[i].peak;
            r.inside_count = beacon_tab[i].inside_cnt;
            r.out_battery = beacon_tab[i].battery;
            r.depart_time = beacon_tab[i].stamp;
            drained.push_back(r);
            in_use[i] = 1'b0;
            beacon_tab[i].present = 1'b0;
            beacon_tab[i].scheduled = 1'b0;
          end
        end
        if (drained.size() > 0) drained[drained.size() - 1].last = 1'b1;
        foreach (drained[k]) expected_results.push_back(drained[k]);
      end
      default: expected_results.push_back(bare_result(ST_IGNORED));
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("beacon_presence_tracker: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", result);
      end else begin
        if (result.status !== expected_results[0].status ||
            result.slot !== expected_results[0].slot ||
            result.present !== expected_results[0].present ||
            result.out_address !== expected_results[0].out_address ||
            result.peak_strength !== expected_results[0].peak_strength ||
            result.inside_count !== expected_results[0].inside_count ||
            result.out_battery !== expected_results[0].out_battery ||
            result.depart_time !== expected_results[0].depart_time ||
            result.departures !== expected_results[0].departures ||
            result.last !== expected_results[0].last) begin
          errors++;
          if (errors <= 10)
            $display("result differs: expected %p got %p", expected_results[0], result);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  task automatic send_item(input item_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    track_item(it);
  endtask

  task automatic pause_sender(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FLOOR:  floor_q = v[7:0];
      REG_INSIDE: inside_thr = v[15:0];
      REG_WEAK:   weak_thr = v[15:0];
      default:    leave_thr = v[15:0];
    endcase
  endtask

  task automatic set_regs(input logic [7:0] fl, input logic [15:0] ins,
                          input logic [15:0] wk, input logic [15:0] lv);
    write_reg(REG_FLOOR, {24'h0, fl});
    write_reg(REG_INSIDE, {16'h0, ins});
    write_reg(REG_WEAK, {16'h0, wk});
    write_reg(REG_LEAVE, {16'h0, lv});
  endtask

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.operation = (pick < 72) ? OP_SIGHT : (pick < 87) ? OP_SCAN :
                   (pick < 97) ? OP_DRAIN : OP_BAD;
    it.beacon_address = ($urandom_range(0, 9) < 9) ? addr_pool[$urandom_range(0, 71)]
                                                    : 48'({$urandom, $urandom});
    it.signal_strength = 8'($urandom);
    it.battery_level = 16'($urandom);
    it.time_now = $urandom;
    return it;
  endfunction

  task automatic random_phase(input int count, input bit with_gaps);
    for (int k = 0; k < count; k++) begin
      send_item(random_item());
      if (with_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 17));
    end
  endtask

  initial begin
    item_t it;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    floor_q = -8'sd80;
    inside_thr = 16'd3;
    weak_thr = 16'd3;
    leave_thr = 16'd3;
    foreach (in_use[i]) begin
      in_use[i] = 1'b0;
      was_seen[i] = 1'b0;
      beacon_tab[i] = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
    addr_pool[0] = 48'h0;
    addr_pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening_rows[r]) begin
      it.operation = opening_rows[r].op;
      it.beacon_address = opening_rows[r].addr;
      it.signal_strength = opening_rows[r].strength;
      it.battery_level = opening_rows[r].batt;
      it.time_now = opening_rows[r].now;
      send_item(it);
      if (opening_rows[r].typed &&
          expected_results[expected_results.size() - 1].status !== opening_rows[r].want) begin
        errors++;
        if (errors <= 10) $display("row %0d: predicted status differs from table", r);
      end
      if (r % 5 == 4) pause_sender($urandom_range(1, 17));
    end
    wait_idle();

    set_regs(8'h80, 16'd0, 16'd0, 16'd0);
    random_phase(80, 1'b1);
    wait_idle();

    set_regs(8'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(40, 1'b1);
    wait_idle();

    set_regs(-8'sd60, 16'd2, 16'd2, 16'd4);
    for (int k = 0; k < 70; k++) begin
      it = random_item();
      it.operation = OP_SIGHT;
      it.beacon_address = addr_pool[k];
      it.signal_strength = 8'($urandom_range(0, 127));
      send_item(it);
    end
    random_phase(70, 1'b1);
    wait_idle();
    random_phase(70, 1'b1);
    wait_idle();

    set_regs(8'($urandom_range(0, 255)), 16'($urandom_range(1, 5)),
             16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)));
    random_phase(60, 1'b0);
    wait_idle();

    if (errors == 0) begin
      $display("beacon_presence_tracker: match");
    end else begin
      $display("beacon_presence_tracker: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
